>>> design/mtkte_pkg.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: shared package
// Key codes, register map, field widths and the keypad character tables.
// ----------------------------------------------------------------------------
package mtkte_pkg;

    localparam int KEY_W     = 4;
    localparam int CHAR_W    = 8;
    localparam int SLOT_W    = 5;
    localparam int TICK_W    = 8;
    localparam int TAP_W     = 2;
    localparam int LKEY_W    = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [TAP_W-1:0]  t_tap;

    // Request types.
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Keys of the fourth column.
    localparam t_key KEY_NUM_MODE    = 4'd3;
    localparam t_key KEY_LETTER_MODE = 4'd7;
    localparam t_key KEY_UPPER       = 4'd11;
    localparam t_key KEY_LOWER       = 4'd15;
    localparam logic [1:0] MODE_COLUMN = 2'd3;

    localparam logic [LKEY_W-1:0] NO_KEY   = 5'd16;
    localparam logic [TICK_W-1:0] TICK_MAX = 8'd255;

    // Register map: word index taken from paddr[2].
    localparam logic REG_REPEAT_WINDOW = 1'b0;
    localparam logic [TICK_W-1:0] REPEAT_WINDOW_RST = 8'd3;

    localparam t_char CHAR_LOWER_A = 8'h61;
    localparam t_char CHAR_LOWER_Z = 8'h7a;
    localparam t_char CASE_OFFSET  = 8'd32;

    function automatic t_char f_digit(input t_key key);
        t_char c;
        unique case (key)
            4'd0:    c = 8'h31;
            4'd1:    c = 8'h32;
            4'd2:    c = 8'h33;
            4'd4:    c = 8'h34;
            4'd5:    c = 8'h35;
            4'd6:    c = 8'h36;
            4'd8:    c = 8'h37;
            4'd9:    c = 8'h38;
            4'd10:   c = 8'h39;
            4'd12:   c = 8'h23;
            4'd13:   c = 8'h30;
            4'd14:   c = 8'h2a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] f_group_len(input t_key key);
        logic [1:0] n;
        unique case (key)
            4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9: n = 2'd3;
            4'd10:   n = 2'd2;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

    // The letter groups are runs of the alphabet, so a base letter plus the
    // tap index gives the character.
    function automatic t_char f_group_char(input t_key key, input t_tap idx);
        t_char base;
        t_char c;
        unique case (key)
            4'd0:    base = 8'h61;
            4'd1:    base = 8'h64;
            4'd2:    base = 8'h67;
            4'd4:    base = 8'h6a;
            4'd5:    base = 8'h6d;
            4'd6:    base = 8'h70;
            4'd8:    base = 8'h73;
            4'd9:    base = 8'h76;
            4'd10:   base = 8'h79;
            4'd12:   base = 8'h23;
            4'd13:   base = 8'h20;
            4'd14:   base = 8'h2a;
            default: base = 8'h00;
        endcase
        if (idx >= t_tap'(f_group_len(key)) || base == 8'h00) begin
            c = 8'h00;
        end else begin
            c = base + t_char'(idx);
        end
        return c;
    endfunction

    // (tap + 1) modulo the group length, exact for every tap value.
    function automatic t_tap f_next_tap(input t_tap tap, input logic [1:0] len);
        logic [2:0] inc;
        t_tap       r;
        inc = 3'(tap) + 3'd1;
        unique case (len)
            2'd2:    r = t_tap'(inc[0]);
            2'd3:    r = (inc >= 3'd3) ? t_tap'(inc - 3'd3) : t_tap'(inc);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> design/multi_tap_keypad_text_entry.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry
// Turns key presses and timer ticks into characters and text slot numbers.
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle; the result register drains while the next
// beat is taken, and only a stalled full result register holds the input.
// Reset (i_rst_n low, synchronous): number mode, lower case, no last key,
// tick and slot counts zero, repeat window 3, result register empty.
module multi_tap_keypad_text_entry
    import mtkte_pkg::*;
#(
    parameter int TEXT_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [KEY_W-1:0]   i_key,
    // Result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_char_valid,
    output logic [CHAR_W-1:0]  o_char_code,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_buffer_cleared,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CNT_W = $clog2(TEXT_SLOTS + 1);
    localparam int EXT_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(TEXT_SLOTS);

    logic [TICK_W-1:0] r_repeat_window;
    logic              r_letter_mode, n_letter_mode;
    logic              r_upper_case,  n_upper_case;
    logic [LKEY_W-1:0] r_last_key,    n_last_key;
    t_tap              r_tap,         n_tap;
    logic [TICK_W-1:0] r_tick,        n_tick;
    logic [CNT_W-1:0]  r_slot_count,  n_slot_count;

    logic              r_out_valid;
    logic              r_char_valid,  n_char_valid;
    t_char             r_char_code,   n_char_code;
    logic [SLOT_W-1:0] r_slot,        n_slot;
    logic              r_cleared,     n_cleared;

    logic              in_accept;
    logic              cfg_write;
    logic              open_slot;
    logic              repeat_hit;
    logic [CNT_W-1:0]  slot_m1;
    logic [EXT_W-1:0]  slot_ext;
    t_char             letter;

    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;
    assign cfg_write = psel & penable & pwrite;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REPEAT_WINDOW) ? PDATA_W'(r_repeat_window) : '0;

    always_comb begin
        n_letter_mode = r_letter_mode;
        n_upper_case  = r_upper_case;
        n_last_key    = r_last_key;
        n_tap         = r_tap;
        n_tick        = r_tick;
        n_slot_count  = r_slot_count;
        n_char_valid  = 1'b0;
        n_char_code   = '0;
        n_cleared     = 1'b0;
        open_slot     = 1'b0;
        letter        = '0;
        repeat_hit    = (r_tick <= r_repeat_window) && (r_last_key == LKEY_W'(i_key));

        if (i_req_type == REQ_TICK) begin
            if (r_tick != TICK_MAX) begin
                n_tick = r_tick + TICK_W'(1);
            end
        end else if (i_key[1:0] == MODE_COLUMN) begin
            unique case (i_key)
                KEY_NUM_MODE:    n_letter_mode = 1'b0;
                KEY_LETTER_MODE: n_letter_mode = 1'b1;
                KEY_UPPER:       n_upper_case  = 1'b1;
                default:         n_upper_case  = 1'b0;
            endcase
        end else begin
            n_char_valid = 1'b1;
            if (!r_letter_mode) begin
                open_slot   = 1'b1;
                n_char_code = f_digit(i_key);
            end else begin
                if (repeat_hit) begin
                    n_tap = f_next_tap(r_tap, f_group_len(i_key));
                end else begin
                    n_tap     = '0;
                    open_slot = 1'b1;
                end
                n_last_key = LKEY_W'(i_key);
                n_tick     = '0;
                letter     = f_group_char(i_key, n_tap);
                if (r_upper_case && letter >= CHAR_LOWER_A && letter <= CHAR_LOWER_Z) begin
                    n_char_code = letter - CASE_OFFSET;
                end else begin
                    n_char_code = letter;
                end
            end
        end

        // A new slot past the end of the buffer clears the text and restarts.
        if (open_slot) begin
            if (r_slot_count >= SLOTS) begin
                n_slot_count = CNT_W'(1);
                n_cleared    = 1'b1;
            end else begin
                n_slot_count = r_slot_count + CNT_W'(1);
            end
        end
    end

    always_comb begin
        slot_m1  = n_slot_count - CNT_W'(1);
        slot_ext = EXT_W'(slot_m1);
        if (!n_char_valid || n_slot_count == '0) begin
            n_slot = '0;
        end else begin
            n_slot = slot_ext[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_window <= REPEAT_WINDOW_RST;
            r_letter_mode   <= 1'b0;
            r_upper_case    <= 1'b0;
            r_last_key      <= NO_KEY;
            r_tap           <= '0;
            r_tick          <= '0;
            r_slot_count    <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == REG_REPEAT_WINDOW) begin
                r_repeat_window <= pwdata[TICK_W-1:0];
            end
            if (in_accept) begin
                r_letter_mode <= n_letter_mode;
                r_upper_case  <= n_upper_case;
                r_last_key    <= n_last_key;
                r_tap         <= n_tap;
                r_tick        <= n_tick;
                r_slot_count  <= n_slot_count;
                r_out_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_char_valid <= n_char_valid;
            r_char_code  <= n_char_code;
            r_slot       <= n_slot;
            r_cleared    <= n_cleared;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_char_valid     = r_char_valid;
    assign o_char_code      = r_char_code;
    assign o_slot           = r_slot;
    assign o_buffer_cleared = r_cleared;

endmodule

>>> design/mtkte_checker.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: port checker
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module mtkte_checker
    import mtkte_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_req_type,
    input logic [KEY_W-1:0]   i_key,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_char_valid,
    input logic [CHAR_W-1:0]  o_char_code,
    input logic [SLOT_W-1:0]  o_slot,
    input logic               o_buffer_cleared
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code) && $stable(o_slot)
            && $stable(o_char_valid) && $stable(o_buffer_cleared))
        else $error("result beat changed while stalled");

    // A beat that writes no character carries all-zero fields.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_char_code == '0 && o_slot == '0
            && !o_buffer_cleared)
        else $error("non-character beat has non-zero fields");

    // Every written character is a real one, and a cleared buffer restarts at slot 0.
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_char_valid |-> o_char_code != '0
            && (!o_buffer_cleared || o_slot == '0))
        else $error("written character is null or cleared slot is not zero");

    // The result register is empty straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind multi_tap_keypad_text_entry mtkte_checker u_mtkte_checker (.*);
